@@ design/tcr_pkg.sv @@
`timescale 1ns / 1ps

package tcr_pkg;

  localparam int unsigned MaxConnsDef      = 16;
  localparam int unsigned ReorderDepthDef  = 8;
  localparam int unsigned PurgeIntervalDef = 64;
  localparam logic [31:0] TimeoutReset     = 32'd300000;
  localparam int unsigned KeyShift         = 24;
  localparam int unsigned KeyW             = 58;
  localparam int unsigned MaxResults       = 26;
  localparam logic [1:0]  FinClose         = 2'd2;

  localparam int unsigned InDataW  = 192;
  localparam int unsigned OutDataW = 56;

  typedef enum logic [1:0] {
    EV_OPEN    = 2'd0,
    EV_DELIVER = 2'd1,
    EV_CLOSE   = 2'd2
  } event_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [15:0]     port;
    logic [31:0]     nsi;
    logic [31:0]     nsr;
    logic [1:0]      fin;
    logic [31:0]     la;
  } conn_row_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] handle;
  } seg_row_t;

  typedef struct packed {
    event_e      kind;
    logic [3:0]  slot;
    logic        fi;
    logic [15:0] port;
    logic [15:0] handle;
    logic [15:0] len;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_OPEN,
    S_PROC,
    S_DRN_RD,
    S_DRN_CMP,
    S_CLOSE_END,
    S_POST,
    S_CLOSE_POST,
    S_PURGE_CHK,
    S_PRG_RD,
    S_PRG_CMP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_conn;
    logic srch_step;
    logic idx_inc;
    logic open;
    logic set_resp;
    logic dlv;
    logic buf_wr;
    logic rd_seg;
    logic drn_take;
    logic drn_step;
    logic close_cur;
    logic post;
    logic purge_cnt;
    logic prg_close;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic idx_last;
    logic hit;
    logic free_found;
    logic syn;
    logic ack;
    logic len_zero;
    logic seq_eq;
    logic seq_gt;
    logic buf_full;
    logic drn_match;
    logic bidx_last;
    logic post_close;
    logic purge_due;
    logic prg_expired;
    logic emit_ok;
  } status_t;

endpackage

@@ design/tcr_ram.sv @@
`timescale 1ns / 1ps

module tcr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tcr_ctrl.sv @@
`timescale 1ns / 1ps

module tcr_ctrl import tcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SRCH_RD;
      end
      S_SRCH_RD: state_d = S_SRCH_CMP;
      S_SRCH_CMP: begin
        state_d = (st_i.match || st_i.idx_last) ? S_DECIDE : S_SRCH_RD;
      end
      S_DECIDE: begin
        if (st_i.syn && !st_i.ack) begin
          if (st_i.hit) state_d = S_CLOSE_END;
          else if (st_i.free_found) state_d = S_OPEN;
          else state_d = S_FINISH;
        end else begin
          state_d = st_i.hit ? S_PROC : S_FINISH;
        end
      end
      S_OPEN: begin
        if (st_i.emit_ok) state_d = S_PROC;
      end
      S_PROC: begin
        if (st_i.len_zero) state_d = S_POST;
        else if (st_i.seq_eq) begin
          if (st_i.emit_ok) state_d = S_DRN_RD;
        end else if (st_i.seq_gt) state_d = S_POST;
        else if (st_i.buf_full) state_d = S_CLOSE_END;
        else state_d = S_POST;
      end
      S_DRN_RD: state_d = S_DRN_CMP;
      S_DRN_CMP: begin
        if (st_i.drn_match) begin
          if (st_i.emit_ok) state_d = S_DRN_RD;
        end else begin
          state_d = st_i.bidx_last ? S_POST : S_DRN_RD;
        end
      end
      S_CLOSE_END: begin
        if (st_i.emit_ok) state_d = S_FINISH;
      end
      S_POST: state_d = st_i.post_close ? S_CLOSE_POST : S_PURGE_CHK;
      S_CLOSE_POST: begin
        if (st_i.emit_ok) state_d = S_PURGE_CHK;
      end
      S_PURGE_CHK: state_d = st_i.purge_due ? S_PRG_RD : S_FINISH;
      S_PRG_RD: state_d = S_PRG_CMP;
      S_PRG_CMP: begin
        if (!st_i.prg_expired || st_i.emit_ok) begin
          state_d = st_i.idx_last ? S_FINISH : S_PRG_RD;
        end
      end
      S_FINISH: begin
        if (st_i.emit_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SRCH_RD: cmd_o.rd_conn = 1'b1;
      S_SRCH_CMP: begin
        cmd_o.srch_step = 1'b1;
        cmd_o.idx_inc   = !st_i.match && !st_i.idx_last;
      end
      S_DECIDE: cmd_o.set_resp = st_i.syn && st_i.ack && st_i.hit;
      S_OPEN: cmd_o.open = st_i.emit_ok;
      S_PROC: begin
        if (!st_i.len_zero) begin
          if (st_i.seq_eq) cmd_o.dlv = st_i.emit_ok;
          else if (!st_i.seq_gt && !st_i.buf_full) cmd_o.buf_wr = 1'b1;
        end
      end
      S_DRN_RD: cmd_o.rd_seg = 1'b1;
      S_DRN_CMP: begin
        cmd_o.drn_take = st_i.drn_match && st_i.emit_ok;
        cmd_o.drn_step = !st_i.drn_match && !st_i.bidx_last;
      end
      S_CLOSE_END, S_CLOSE_POST: cmd_o.close_cur = st_i.emit_ok;
      S_POST: cmd_o.post = 1'b1;
      S_PURGE_CHK: cmd_o.purge_cnt = 1'b1;
      S_PRG_RD: cmd_o.rd_conn = 1'b1;
      S_PRG_CMP: begin
        cmd_o.prg_close = st_i.prg_expired && st_i.emit_ok;
        cmd_o.idx_inc   = (!st_i.prg_expired || st_i.emit_ok) && !st_i.idx_last;
      end
      S_FINISH: cmd_o.finish = st_i.emit_ok;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ design/tcr_dp.sv @@
`timescale 1ns / 1ps

module tcr_dp import tcr_pkg::*; #(
  parameter int unsigned MAX_CONNS      = MaxConnsDef,
  parameter int unsigned REORDER_DEPTH  = ReorderDepthDef,
  parameter int unsigned PURGE_INTERVAL = PurgeIntervalDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [3:0]          in_user_i,
  input  cmd_t                cmd_i,
  output status_t             st_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output res_t                out_res_o,
  output logic                out_last_o
);

  localparam int unsigned CIW  = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
  localparam int unsigned BIW  = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
  localparam int unsigned NDIR = MAX_CONNS * 2;
  localparam int unsigned DIW  = CIW + 1;
  localparam int unsigned NSEG = NDIR * REORDER_DEPTH;
  localparam int unsigned SAW  = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam int unsigned PCW  = (PURGE_INTERVAL > 1) ? $clog2(PURGE_INTERVAL) : 1;
  localparam int unsigned ECW  = $clog2(MaxResults + 1);

  logic [31:0]   timeout_q;
  logic [KeyW-1:0] key_q;
  logic [15:0]   dport_q, len_q, handle_q;
  logic [31:0]   seq_q, now_q;
  logic          syn_q, ack_q, fin_q, rst_q;

  logic [MAX_CONNS-1:0]     connv_q, connv_d;
  logic [REORDER_DEPTH-1:0] segv_q [NDIR];
  logic [REORDER_DEPTH-1:0] segv_d [NDIR];
  logic [CIW-1:0] idx_q, slot_q, free_slot_q;
  logic [BIW-1:0] bidx_q;
  logic           hit_q, free_found_q;
  logic [PCW-1:0] pcnt_q;
  logic [ECW-1:0] ecnt_q;
  conn_row_t      wk_q, conn_rd, post_row;
  seg_row_t       seg_rd, seg_wr;

  res_t           pend_q, out_q, emit_res;
  logic           pend_v_q, out_v_q, out_last_q;
  logic           emit_req, out_free, out_load;

  logic           fi;
  logic [31:0]    nx, nx_post;
  logic [DIW-1:0] dir;
  logic [REORDER_DEPTH-1:0] win;
  logic [BIW-1:0] free_pos;
  logic [SAW-1:0] seg_base;
  logic [1:0]     fin_nx;
  logic [32:0]    ipsum;
  logic [16:0]    psum;

  assign fi       = (dport_q == wk_q.port);
  assign nx       = fi ? wk_q.nsi : wk_q.nsr;
  assign dir      = {slot_q, fi};
  assign win      = segv_q[dir];
  assign seg_base = SAW'(dir) * SAW'(REORDER_DEPTH);
  assign fin_nx   = wk_q.fin + {1'b0, fin_q};
  assign nx_post  = nx + {31'd0, syn_q};

  always_comb begin
    free_pos = '0;
    for (int j = REORDER_DEPTH - 1; j >= 0; j--) begin
      if (!win[j]) free_pos = BIW'(j);
    end
  end

  assign ipsum = {1'b0, in_data_i[31:0]} + {1'b0, in_data_i[63:32]};
  assign psum  = {1'b0, in_data_i[79:64]} + {1'b0, in_data_i[95:80]};

  tcr_ram #(.Width($bits(conn_row_t)), .Depth(MAX_CONNS)) u_conn_ram (
    .clk_i,
    .we_i    (cmd_i.post),
    .waddr_i (slot_q),
    .wdata_i (post_row),
    .re_i    (cmd_i.rd_conn),
    .raddr_i (idx_q),
    .rdata_o (conn_rd)
  );

  assign seg_wr = '{seq: seq_q, len: len_q, handle: handle_q};

  tcr_ram #(.Width($bits(seg_row_t)), .Depth(NSEG)) u_seg_ram (
    .clk_i,
    .we_i    (cmd_i.buf_wr),
    .waddr_i (seg_base + SAW'(free_pos)),
    .wdata_i (seg_wr),
    .re_i    (cmd_i.rd_seg),
    .raddr_i (seg_base + SAW'(bidx_q)),
    .rdata_o (seg_rd)
  );

  always_comb begin
    post_row     = wk_q;
    post_row.la  = now_q;
    post_row.fin = fin_nx;
    if (fi) post_row.nsi = nx_post;
    else post_row.nsr = nx_post;
  end

  assign out_free = !out_v_q || out_ready_i;
  assign out_load = pend_v_q && ((emit_req && (ecnt_q < ECW'(MaxResults))) || cmd_i.finish);

  always_comb begin
    st_o             = '0;
    st_o.match       = connv_q[idx_q] && (conn_rd.key == key_q);
    st_o.idx_last    = (idx_q == CIW'(MAX_CONNS - 1));
    st_o.hit         = hit_q;
    st_o.free_found  = free_found_q;
    st_o.syn         = syn_q;
    st_o.ack         = ack_q;
    st_o.len_zero    = (len_q == '0);
    st_o.seq_eq      = (nx == seq_q);
    st_o.seq_gt      = (nx > seq_q);
    st_o.buf_full    = &win;
    st_o.drn_match   = win[bidx_q] && (seg_rd.seq == nx);
    st_o.bidx_last   = (bidx_q == BIW'(REORDER_DEPTH - 1));
    st_o.post_close  = (fin_nx == FinClose) || rst_q;
    st_o.purge_due   = (pcnt_q == PCW'(PURGE_INTERVAL - 1));
    st_o.prg_expired = connv_q[idx_q] && ((now_q - conn_rd.la) > timeout_q);
    st_o.emit_ok     = !pend_v_q || out_free;
  end

  always_comb begin
    emit_res = '{kind: EV_CLOSE, slot: 4'(slot_q), fi: 1'b0, port: 16'd0,
                 handle: 16'd0, len: 16'd0};
    emit_req = cmd_i.open | cmd_i.dlv | cmd_i.drn_take | cmd_i.close_cur | cmd_i.prg_close;
    if (cmd_i.open) begin
      emit_res.kind = EV_OPEN;
      emit_res.slot = 4'(free_slot_q);
      emit_res.port = dport_q;
    end else if (cmd_i.dlv) begin
      emit_res.kind   = EV_DELIVER;
      emit_res.fi     = fi;
      emit_res.handle = handle_q;
      emit_res.len    = len_q;
    end else if (cmd_i.drn_take) begin
      emit_res.kind   = EV_DELIVER;
      emit_res.fi     = fi;
      emit_res.handle = seg_rd.handle;
      emit_res.len    = seg_rd.len;
    end else if (cmd_i.prg_close) begin
      emit_res.slot = 4'(idx_q);
    end
  end

  always_comb begin
    connv_d = connv_q;
    segv_d  = segv_q;
    if (cmd_i.open) begin
      connv_d[free_slot_q]        = 1'b1;
      segv_d[{free_slot_q, 1'b0}] = '0;
      segv_d[{free_slot_q, 1'b1}] = '0;
    end
    if (cmd_i.buf_wr) segv_d[dir][free_pos] = 1'b1;
    if (cmd_i.drn_take) segv_d[dir][bidx_q] = 1'b0;
    if (cmd_i.close_cur) begin
      connv_d[slot_q]        = 1'b0;
      segv_d[{slot_q, 1'b0}] = '0;
      segv_d[{slot_q, 1'b1}] = '0;
    end
    if (cmd_i.prg_close) begin
      connv_d[idx_q]        = 1'b0;
      segv_d[{idx_q, 1'b0}] = '0;
      segv_d[{idx_q, 1'b1}] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TimeoutReset;
      connv_q      <= '0;
      for (int d = 0; d < NDIR; d++) segv_q[d] <= '0;
      idx_q        <= '0;
      slot_q       <= '0;
      free_slot_q  <= '0;
      bidx_q       <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      pcnt_q       <= '0;
      ecnt_q       <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) timeout_q <= cfg_data_i;
      connv_q <= connv_d;
      segv_q  <= segv_d;
      if (cmd_i.load) begin
        idx_q        <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        ecnt_q       <= '0;
      end
      if (cmd_i.srch_step) begin
        if (st_o.match) begin
          hit_q  <= 1'b1;
          slot_q <= idx_q;
        end
        if (!connv_q[idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
          free_slot_q  <= idx_q;
        end
      end
      if (cmd_i.idx_inc) idx_q <= idx_q + CIW'(1);
      if (cmd_i.open) slot_q <= free_slot_q;
      if (cmd_i.dlv || cmd_i.drn_take) bidx_q <= '0;
      else if (cmd_i.drn_step) bidx_q <= bidx_q + BIW'(1);
      if (cmd_i.purge_cnt) begin
        idx_q  <= '0;
        pcnt_q <= st_o.purge_due ? '0 : pcnt_q + PCW'(1);
      end
      if (out_load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      if (emit_req && (ecnt_q < ECW'(MaxResults))) begin
        ecnt_q   <= ecnt_q + ECW'(1);
        pend_v_q <= 1'b1;
        if (pend_v_q) begin
          out_last_q <= 1'b0;
        end
      end
      if (cmd_i.finish && pend_v_q) begin
        pend_v_q   <= 1'b0;
        out_last_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q    <= {1'b0, ipsum, 7'd0, psum};
      dport_q  <= in_data_i[95:80];
      seq_q    <= in_data_i[127:96];
      len_q    <= in_data_i[143:128];
      handle_q <= in_data_i[159:144];
      now_q    <= in_data_i[191:160];
      syn_q    <= in_user_i[0];
      ack_q    <= in_user_i[1];
      fin_q    <= in_user_i[2];
      rst_q    <= in_user_i[3];
    end
    if (cmd_i.srch_step && st_o.match) wk_q <= conn_rd;
    if (cmd_i.open) begin
      wk_q.key  <= key_q;
      wk_q.port <= dport_q;
      wk_q.nsi  <= seq_q;
      wk_q.nsr  <= '0;
      wk_q.fin  <= '0;
    end
    if (cmd_i.set_resp) wk_q.nsr <= seq_q;
    if (cmd_i.dlv || cmd_i.drn_take) begin
      if (fi) wk_q.nsi <= nx + {16'd0, emit_res.len};
      else wk_q.nsr <= nx + {16'd0, emit_res.len};
    end
    if (emit_req && (ecnt_q < ECW'(MaxResults))) begin
      pend_q <= emit_res;
      if (pend_v_q) out_q <= pend_q;
    end
    if (cmd_i.finish && pend_v_q) out_q <= pend_q;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

@@ design/tcp_connection_reassembly_core.sv @@
`timescale 1ns / 1ps
// TCP connection reassembly core.
// The slave stream takes one segment descriptor per word, with the TCP flags
// in tuser; the master stream returns open, deliver and close events, with
// tlast on the final event caused by that segment. A segment may cause none.
// Timeout is written through the cfg channel, which is always ready.
// One segment is handled at a time. The connection table is searched slot by
// slot through its RAM, up to the hit or over all MAX_CONNS slots on a miss.
// Each reorder buffer scan during draining reads the entries one by one and
// restarts after every drained segment. Every PURGE_INTERVAL counted segments
// a purge walk reads all MAX_CONNS slots.
// Events wait in a one-word holding stage and an output register; when the
// receiver stalls, the block stalls and accepts nothing new until the last
// event of the current segment has entered the output register.
// Reset empties the table and the reorder buffers at once through valid bits
// and restores the timeout to 300000 ms; no clearing pass is needed.
module tcp_connection_reassembly_core import tcr_pkg::*; #(
  parameter int unsigned MAX_CONNS      = MaxConnsDef,
  parameter int unsigned REORDER_DEPTH  = ReorderDepthDef,
  parameter int unsigned PURGE_INTERVAL = PurgeIntervalDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // src_ip, dst_ip, src_port, dst_port, seq_number, payload_length,
  // payload_handle, now_ms
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // flag_syn, flag_ack, flag_fin, flag_rst
  input  logic [3:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // slot, local_port, out_handle, out_length, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // event_kind, from_initiator
  output logic [2:0]          m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  cmd_t    cmd;
  status_t st;
  res_t    res;

  assign cfg_ready_o = 1'b1;

  tcr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tcr_dp #(
    .MAX_CONNS      (MAX_CONNS),
    .REORDER_DEPTH  (REORDER_DEPTH),
    .PURGE_INTERVAL (PURGE_INTERVAL)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, res.len, res.handle, res.port, res.slot};
  assign m_axis_tuser_o = {res.fi, res.kind};

endmodule

@@ design/tcr_checker.sv @@
`timescale 1ns / 1ps

module tcr_checker import tcr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic [2:0]          m_axis_tuser_o,
  input logic                m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second segment taken while one is in work");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o[1:0] != 2'd3)
    else $error("undefined event kind");

  a_open_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == EV_OPEN |->
      m_axis_tdata_o[51:20] == '0 && !m_axis_tuser_o[2])
    else $error("open event carries payload fields");

endmodule

bind tcp_connection_reassembly_core tcr_checker u_tcr_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid_i,
  .s_axis_tready_o,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tuser_o,
  .m_axis_tlast_o
);
